@@ hdl/mkd_pkg.sv @@
// Shared types, constants and character table for the Morse key decoder.
package mkd_pkg;

    localparam int unsigned MAX_SYMBOLS = 5;
    localparam int unsigned SPAN_W      = 16;
    localparam int unsigned CNT_W       = 3;
    localparam int unsigned CODE_W      = 7;
    localparam int unsigned IDX_W       = MAX_SYMBOLS + 1;

    localparam logic [SPAN_W-1:0] SPAN_MAX = '1;

    localparam logic [SPAN_W-1:0] DEBOUNCE_RST = 16'd30;
    localparam logic [SPAN_W-1:0] DASH_RST     = 16'd400;
    localparam logic [SPAN_W-1:0] LONG_RST     = 16'd1200;
    localparam logic [SPAN_W-1:0] GAP_RST      = 16'd1200;

    typedef enum logic [1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_DASH     = 2'd1,
        REG_LONG     = 2'd2,
        REG_GAP      = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        EV_DOT     = 3'd0,
        EV_DASH    = 3'd1,
        EV_LONG    = 3'd2,
        EV_CHAR    = 3'd3,
        EV_NOMATCH = 3'd4
    } t_event;

    typedef struct packed {
        logic [SPAN_W-1:0] debounce_ms;
        logic [SPAN_W-1:0] dash_ms;
        logic [SPAN_W-1:0] long_ms;
        logic [SPAN_W-1:0] gap_ms;
    } t_cfg;

    // Edge classification from the timer; at most one flag is set.
    typedef struct packed {
        logic dot;
        logic dash;
        logic long_press;
        logic char_end;
    } t_key_evt;

    // Index is a leading marker bit above the symbol bits, dash = 1.
    function automatic logic [CODE_W-1:0] decode_char(input logic [IDX_W-1:0] idx);
        logic [CODE_W-1:0] ch;
        begin
            unique case (idx)
                6'd2:  ch = 7'h45; // E
                6'd3:  ch = 7'h54; // T
                6'd4:  ch = 7'h49; // I
                6'd5:  ch = 7'h4E; // N
                6'd6:  ch = 7'h41; // A
                6'd7:  ch = 7'h4D; // M
                6'd8:  ch = 7'h53; // S
                6'd9:  ch = 7'h44; // D
                6'd10: ch = 7'h52; // R
                6'd11: ch = 7'h47; // G
                6'd12: ch = 7'h55; // U
                6'd13: ch = 7'h4B; // K
                6'd14: ch = 7'h57; // W
                6'd15: ch = 7'h4F; // O
                6'd16: ch = 7'h48; // H
                6'd17: ch = 7'h42; // B
                6'd18: ch = 7'h4C; // L
                6'd19: ch = 7'h5A; // Z
                6'd20: ch = 7'h46; // F
                6'd21: ch = 7'h43; // C
                6'd22: ch = 7'h50; // P
                6'd24: ch = 7'h56; // V
                6'd25: ch = 7'h58; // X
                6'd27: ch = 7'h51; // Q
                6'd29: ch = 7'h59; // Y
                6'd30: ch = 7'h4A; // J
                6'd32: ch = 7'h35; // 5
                6'd33: ch = 7'h36; // 6
                6'd35: ch = 7'h37; // 7
                6'd39: ch = 7'h38; // 8
                6'd47: ch = 7'h39; // 9
                6'd48: ch = 7'h34; // 4
                6'd56: ch = 7'h33; // 3
                6'd60: ch = 7'h32; // 2
                6'd62: ch = 7'h31; // 1
                6'd63: ch = 7'h30; // 0
                default: ch = '0;
            endcase
            return ch;
        end
    endfunction

endpackage

@@ hdl/mkd_timer.sv @@
// Key level timer: span counter and press/gap classification.
module mkd_timer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic                        i_level,
    input  mkd_pkg::t_cfg               i_cfg,
    output mkd_pkg::t_key_evt           o_evt
);

    logic                        r_last_level;
    logic [mkd_pkg::SPAN_W-1:0]  r_span;
    logic [mkd_pkg::SPAN_W-1:0]  n_span;
    logic                        w_toggle;

    assign w_toggle = i_level != r_last_level;

    always_comb begin
        o_evt = '0;
        if (w_toggle) begin
            if (!i_level) begin
                // release: earlier test wins
                if (r_span <= i_cfg.debounce_ms) begin
                    o_evt = '0;
                end else if (r_span < i_cfg.dash_ms) begin
                    o_evt.dot = 1'b1;
                end else if (r_span < i_cfg.long_ms) begin
                    o_evt.dash = 1'b1;
                end else begin
                    o_evt.long_press = 1'b1;
                end
            end else if (r_span > i_cfg.gap_ms) begin
                o_evt.char_end = 1'b1;
            end
        end
    end

    always_comb begin
        if (w_toggle) begin
            n_span = mkd_pkg::SPAN_W'(1);
        end else if (r_span != mkd_pkg::SPAN_MAX) begin
            n_span = r_span + mkd_pkg::SPAN_W'(1);
        end else begin
            n_span = r_span;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level <= 1'b0;
            r_span       <= '0;
        end else if (i_accept) begin
            r_last_level <= i_level;
            r_span       <= n_span;
        end
    end

endmodule

@@ hdl/mkd_symbols.sv @@
// Symbol store and character decode; forms the result word for each event.
module mkd_symbols (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  mkd_pkg::t_key_evt           i_evt,
    output logic                        o_res_valid,
    output mkd_pkg::t_event             o_res_kind,
    output logic [mkd_pkg::CODE_W-1:0]  o_res_code
);

    logic [mkd_pkg::MAX_SYMBOLS-1:0] r_bits;
    logic [mkd_pkg::CNT_W-1:0]       r_count;
    logic                            r_overflow;

    logic [mkd_pkg::IDX_W-1:0]       w_marker;
    logic [mkd_pkg::IDX_W-1:0]       w_idx;
    logic [mkd_pkg::CODE_W-1:0]      w_char;
    logic                            w_full;
    logic                            w_store;

    assign w_full   = r_count >= mkd_pkg::CNT_W'(mkd_pkg::MAX_SYMBOLS);
    assign w_marker = mkd_pkg::IDX_W'(1) << r_count;
    assign w_idx    = w_marker | ({1'b0, r_bits} & (w_marker - mkd_pkg::IDX_W'(1)));
    assign w_char   = (r_overflow || r_count == '0) ? '0 : mkd_pkg::decode_char(w_idx);
    assign w_store  = i_evt.dot || i_evt.dash;

    always_comb begin
        o_res_valid = 1'b1;
        o_res_kind  = mkd_pkg::EV_DOT;
        o_res_code  = '0;
        if (i_evt.dash) begin
            o_res_kind = mkd_pkg::EV_DASH;
        end else if (i_evt.long_press) begin
            o_res_kind = mkd_pkg::EV_LONG;
        end else if (i_evt.char_end) begin
            if (w_char != '0) begin
                o_res_kind = mkd_pkg::EV_CHAR;
                o_res_code = w_char;
            end else begin
                o_res_kind = mkd_pkg::EV_NOMATCH;
            end
        end else if (!i_evt.dot) begin
            o_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits     <= '0;
            r_count    <= '0;
            r_overflow <= 1'b0;
        end else if (i_accept) begin
            if (i_evt.char_end) begin
                r_bits     <= '0;
                r_count    <= '0;
                r_overflow <= 1'b0;
            end else if (w_store) begin
                if (w_full) begin
                    r_overflow <= 1'b1;
                end else begin
                    r_bits[r_count[$clog2(mkd_pkg::MAX_SYMBOLS)-1:0]] <= i_evt.dash;
                    r_count <= r_count + mkd_pkg::CNT_W'(1);
                end
            end
        end
    end

endmodule

@@ hdl/morse_key_decoder_core.sv @@
// Top level of the Morse key decoder: config registers, timer, symbols, output register.
//
// Feed one key sample per millisecond tick on the slave stream (tdata bit 0,
// 1 = pressed). Each accepted sample yields zero or one result word on the
// master stream: event kind (dot, dash, long press, character, no match) and
// the ASCII code of a decoded character. Presses up to debounce_ms ticks are
// dropped; symbols are collected until a press follows a gap above gap_ms.
// The result word is registered: it appears on the master side the cycle after its
// sample is accepted. Throughput: one sample per cycle while s_axis_tready is high;
// the span counter, classification and table decode are all combinational.
// The result register parts the two sides: a new sample is taken while the
// previous word waits, as long as the downstream takes it in the same cycle;
// otherwise s_axis_tready drops and the input stalls with no loss.
// Reset (synchronous, active low) restores the default thresholds
// (30, 400, 1200, 1200), clears the counter, symbols and the output word.
// Write thresholds through the config port only while the block is idle.
module morse_key_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [0] key_level, [7:1] zero
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [2:0] event_kind, [9:3] char_code, [15:10] zero
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    mkd_pkg::t_cfg               r_cfg;
    mkd_pkg::t_key_evt           w_evt;
    logic                        w_accept;
    logic                        w_res_valid;
    mkd_pkg::t_event             w_res_kind;
    logic [mkd_pkg::CODE_W-1:0]  w_res_code;

    logic                        r_out_valid;
    mkd_pkg::t_event             r_out_kind;
    logic [mkd_pkg::CODE_W-1:0]  r_out_code;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms <= mkd_pkg::DEBOUNCE_RST;
            r_cfg.dash_ms     <= mkd_pkg::DASH_RST;
            r_cfg.long_ms     <= mkd_pkg::LONG_RST;
            r_cfg.gap_ms      <= mkd_pkg::GAP_RST;
        end else if (i_cfg_we) begin
            unique case (mkd_pkg::t_reg_idx'(i_cfg_idx))
                mkd_pkg::REG_DEBOUNCE: r_cfg.debounce_ms <= i_cfg_data;
                mkd_pkg::REG_DASH:     r_cfg.dash_ms     <= i_cfg_data;
                mkd_pkg::REG_LONG:     r_cfg.long_ms     <= i_cfg_data;
                mkd_pkg::REG_GAP:      r_cfg.gap_ms      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mkd_timer u_timer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_level  (i_s_axis_tdata[0]),
        .i_cfg    (r_cfg),
        .o_evt    (w_evt)
    );

    mkd_symbols u_symbols (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_evt       (w_evt),
        .o_res_valid (w_res_valid),
        .o_res_kind  (w_res_kind),
        .o_res_code  (w_res_code)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= w_res_valid;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // load payload only when a new word is produced
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_kind <= mkd_pkg::EV_DOT;
            r_out_code <= '0;
        end else if (w_accept && w_res_valid) begin
            r_out_kind <= w_res_kind;
            r_out_code <= w_res_code;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_code, r_out_kind};

endmodule

@@ tb/sv/tb.sv @@
// Self-checking stream testbench for morse_key_decoder_core: key timing, symbols and decode.
`timescale 1ns / 1ps

module tb;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned SAT_TICKS   = 65540;

    // Dot/dash tree in heap order: node 1 is the root, dot goes to 2n, dash to 2n+1.
    localparam logic [64*8-1:0] MORSE_TREE =
        "**ETIANMSURWDKGOHVF*L*PJBXCYZQ**54*3***2*******16*******7***8*90";

    typedef struct packed {
        mkd_pkg::t_event            kind;
        logic [mkd_pkg::CODE_W-1:0] code;
    } t_key_event;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_axis_tvalid;
    logic              o_s_axis_tready;
    logic [7:0]        i_s_axis_tdata;   // [0] key_level, [7:1] zero
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready;
    logic [15:0]       o_m_axis_tdata;   // [2:0] event_kind, [9:3] char_code, [15:10] zero
    logic              i_cfg_we;
    mkd_pkg::t_reg_idx i_cfg_idx;
    logic [15:0]       i_cfg_data;

    // key timing state and thresholds as the decoder should hold them
    logic                            key_lvl      = 1'b0;
    logic [mkd_pkg::SPAN_W-1:0]      span_ticks   = '0;
    logic [mkd_pkg::MAX_SYMBOLS-1:0] sym_bits     = '0;
    logic [mkd_pkg::CNT_W-1:0]       sym_cnt      = '0;
    logic                            sym_ovf      = 1'b0;
    logic [mkd_pkg::SPAN_W-1:0]      thr_debounce = mkd_pkg::DEBOUNCE_RST;
    logic [mkd_pkg::SPAN_W-1:0]      thr_dash     = mkd_pkg::DASH_RST;
    logic [mkd_pkg::SPAN_W-1:0]      thr_long     = mkd_pkg::LONG_RST;
    logic [mkd_pkg::SPAN_W-1:0]      thr_gap      = mkd_pkg::GAP_RST;

    t_key_event  key_events_due[$];
    t_key_event  head_event;
    int          fail_count  = 0;
    int unsigned cycle_count = 0;
    int unsigned ticks_sent  = 0;
    int          tx_idle_pct = 8;
    int          rx_idle_pct = 8;
    int          hold_req    = 0;
    int          hold_left   = 0;
    logic        rdy_next;

    morse_key_decoder_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic void store_symbol(input logic is_dash);
        if (sym_cnt < mkd_pkg::MAX_SYMBOLS) begin
            sym_bits[sym_cnt] = is_dash;
            sym_cnt++;
        end else begin
            sym_ovf = 1'b1;
        end
    endfunction

    function automatic void time_key_sample(input logic lvl);
        logic [mkd_pkg::SPAN_W-1:0] span;
        t_key_event                 ev;
        logic                       emit;
        int unsigned                node;
        logic [7:0]                 ch;
        span    = span_ticks;
        emit    = 1'b0;
        ev.kind = mkd_pkg::EV_DOT;
        ev.code = '0;
        if (lvl == key_lvl) begin
            if (span_ticks != mkd_pkg::SPAN_MAX) span_ticks = span_ticks + 1'b1;
        end else begin
            key_lvl    = lvl;
            span_ticks = mkd_pkg::SPAN_W'(1);
            if (!lvl) begin
                // release: bounce wins first, then dot, dash, long
                if (span > thr_debounce) begin
                    emit = 1'b1;
                    if (span < thr_dash) begin
                        store_symbol(1'b0);
                        ev.kind = mkd_pkg::EV_DOT;
                    end else if (span < thr_long) begin
                        store_symbol(1'b1);
                        ev.kind = mkd_pkg::EV_DASH;
                    end else begin
                        ev.kind = mkd_pkg::EV_LONG;
                    end
                end
            end else if (span > thr_gap) begin
                // walk the tree from the first symbol; overflow or empty store never match
                node = 1;
                for (int k = 0; k < sym_cnt; k++) node = node * 2 + sym_bits[k];
                ch = MORSE_TREE[(63 - node) * 8 +: 8];
                if (sym_ovf || sym_cnt == 0 || ch == "*") begin
                    ev.kind = mkd_pkg::EV_NOMATCH;
                end else begin
                    ev.kind = mkd_pkg::EV_CHAR;
                    ev.code = ch[mkd_pkg::CODE_W-1:0];
                end
                sym_bits = '0;
                sym_cnt  = '0;
                sym_ovf  = 1'b0;
                emit     = 1'b1;
            end
        end
        if (emit) key_events_due.push_back(ev);
    endfunction

    // Receiver: random stalls, plus long hold-offs on request
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                rdy_next = 1'b0;
            end else begin
                rdy_next = !(rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct);
            end
            @(negedge i_clk);
            i_m_axis_tready = rdy_next;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (key_events_due.size() == 0) begin
                $error("result word %h arrived with no event pending", o_m_axis_tdata);
                fail_count++;
            end else begin
                head_event = key_events_due.pop_front();
                if (o_m_axis_tdata[2:0] !== head_event.kind) begin
                    $error("event_kind: expected %0d, actual %0d",
                           head_event.kind, o_m_axis_tdata[2:0]);
                    fail_count++;
                end
                if (o_m_axis_tdata[9:3] !== head_event.code) begin
                    $error("char_code: expected %h, actual %h",
                           head_event.code, o_m_axis_tdata[9:3]);
                    fail_count++;
                end
            end
        end
    end

    // Offer one key sample; entered and left at a falling edge.
    task automatic send_sample(input logic lvl);
        begin
            while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
                i_s_axis_tvalid = 1'b0;
                @(negedge i_clk);
            end
            i_s_axis_tvalid = 1'b1;
            i_s_axis_tdata  = {7'd0, lvl};
            @(posedge i_clk);
            while (!o_s_axis_tready) @(posedge i_clk);
            @(negedge i_clk);
            time_key_sample(lvl);
        end
    endtask

    task automatic key_span(input logic lvl, input int unsigned n);
        begin
            repeat (n) send_sample(lvl);
            ticks_sent += n;
        end
    endtask

    task automatic wait_drain();
        begin
            i_s_axis_tvalid = 1'b0;
            while (key_events_due.size() != 0) @(negedge i_clk);
            repeat (4) @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input mkd_pkg::t_reg_idx idx, input logic [15:0] val);
        begin
            i_cfg_we   = 1'b1;
            i_cfg_idx  = idx;
            i_cfg_data = val;
            @(negedge i_clk);
            case (idx)
                mkd_pkg::REG_DEBOUNCE: thr_debounce = val;
                mkd_pkg::REG_DASH:     thr_dash     = val;
                mkd_pkg::REG_LONG:     thr_long     = val;
                mkd_pkg::REG_GAP:      thr_gap      = val;
                default: ;
            endcase
        end
    endtask

    task automatic set_thresholds(input logic [15:0] deb, input logic [15:0] dsh,
                                  input logic [15:0] lng, input logic [15:0] gp);
        begin
            wait_drain();
            write_reg(mkd_pkg::REG_DEBOUNCE, deb);
            write_reg(mkd_pkg::REG_DASH, dsh);
            write_reg(mkd_pkg::REG_LONG, lng);
            write_reg(mkd_pkg::REG_GAP, gp);
            i_cfg_we = 1'b0;
        end
    endtask

    // Press length inside the dot or dash window; thresholds must be in order.
    function automatic int unsigned press_ticks(input logic is_dash);
        if (is_dash) return $urandom_range(int'(thr_long) - 1, thr_dash);
        return $urandom_range(int'(thr_dash) - 1, int'(thr_debounce) + 1);
    endfunction

    // Key the symbols of a tree node, first symbol first, then a closing gap.
    task automatic key_char(input int unsigned node);
        int n;
        begin
            n = 0;
            while ((node >> (n + 1)) != 0) n++;
            for (int k = n - 1; k >= 0; k--) begin
                key_span(1'b1, press_ticks(1'((node >> k) & 1)));
                if (k != 0) key_span(1'b0, $urandom_range(thr_gap, 1));
            end
            key_span(1'b0, $urandom_range(int'(thr_gap) + 4, int'(thr_gap) + 1));
        end
    endtask

    task automatic test_reset_defaults();
        begin
            key_span(1'b0, 1201);   // gap counted from reset ends an empty character
            key_span(1'b1, 30);     // bounce at the limit
            key_span(1'b0, 5);
            key_span(1'b1, 31);     // dot
            key_span(1'b0, 1200);   // gap at the limit keeps the character open
            key_span(1'b1, 400);    // dash
            key_span(1'b0, 3);
            key_span(1'b1, 1199);   // dash
            key_span(1'b0, 3);
            key_span(1'b1, 1200);   // long, not stored
            key_span(1'b0, 1201);
            key_span(1'b1, 1);      // W
            key_span(1'b0, 2);
        end
    endtask

    task automatic test_alphabet();
        begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
            set_thresholds(16'd1, 16'd3, 16'd5, 16'd3);
            for (int node = 2; node < 64; node++) key_char(node);
            key_span(1'b1, 1);
            key_span(1'b0, 1);
            tx_idle_pct = 8;
            rx_idle_pct = 8;
        end
    endtask

    task automatic test_special_cases();
        begin
            set_thresholds(16'd1, 16'd3, 16'd5, 16'd3);
            // sixth symbol overflows the store and spoils the character
            repeat (6) begin
                key_span(1'b1, 2);
                key_span(1'b0, 1);
            end
            key_span(1'b0, 4);
            key_span(1'b1, 2);
            key_span(1'b0, 4);
            key_span(1'b1, 2);      // E, store was cleared
            key_span(1'b0, 1);
            key_span(1'b1, 6);      // long press between symbols
            key_span(1'b0, 1);
            key_span(1'b1, 4);
            key_span(1'b0, 4);
            key_span(1'b1, 1);      // A
            key_span(1'b0, 4);
            key_span(1'b1, 1);      // empty store
            set_thresholds(16'd0, 16'd2, 16'd4, 16'd0);
            key_span(1'b0, 1);
            key_span(1'b1, 1);
            key_span(1'b0, 1);
            key_span(1'b1, 1);
            // thresholds out of order: the earlier test wins
            set_thresholds(16'd5, 16'd2, 16'd8, 16'd3);
            key_span(1'b0, 4);
            key_span(1'b1, 3);
            key_span(1'b0, 1);
            key_span(1'b1, 6);
            key_span(1'b0, 1);
            set_thresholds(16'd0, 16'd9, 16'd3, 16'd3);
            key_span(1'b1, 4);
            key_span(1'b0, 1);
            set_thresholds(16'd0, 16'd0, 16'd0, 16'd3);
            key_span(1'b1, 1);
            key_span(1'b0, 1);
            set_thresholds(16'd0, 16'd0, 16'hFFFF, 16'd3);
            key_span(1'b1, 2);
            key_span(1'b0, 4);
            key_span(1'b1, 1);
            key_span(1'b0, 1);
            set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd3);
            key_span(1'b1, 5);
            key_span(1'b0, 4);
            key_span(1'b1, 1);
            key_span(1'b0, 1);
            set_thresholds(16'd0, 16'hFFFF, 16'hFFFF, 16'd3);
            key_span(1'b1, 5);
            key_span(1'b0, 2);
        end
    endtask

    task automatic test_backpressure();
        begin
            set_thresholds(16'd0, 16'd2, 16'd4, 16'd1);
            hold_req = 200;
            // a word on every press and every release: the output fills and input stalls
            repeat (150) begin
                key_span(1'b1, 1);
                key_span(1'b0, 2);
            end
        end
    endtask

    task automatic test_random_keying();
        logic [15:0] deb, dsh, lng, gp;
        int unsigned stop_at, pick;
        begin
            for (int phase = 0; phase < 5; phase++) begin
                if (phase < 4) begin
                    deb = 16'($urandom_range(3));
                    dsh = 16'(deb + 2 + $urandom_range(3));
                    lng = 16'(dsh + 1 + $urandom_range(4));
                    gp  = 16'($urandom_range(6, 1));
                end else begin
                    deb = 16'($urandom_range(8));
                    dsh = 16'($urandom_range(8));
                    lng = 16'($urandom_range(8));
                    gp  = 16'($urandom_range(8));
                end
                set_thresholds(deb, dsh, lng, gp);
                stop_at = ticks_sent + 250;
                while (ticks_sent < stop_at) begin
                    pick = $urandom_range(99);
                    if (phase == 4 || pick >= 88) begin
                        key_span(1'($urandom_range(1)), $urandom_range(6, 1));
                    end else if (pick < 70) begin
                        key_char(pick < 4 ? $urandom_range(127, 64) : $urandom_range(63, 2));
                    end else if (pick < 80) begin
                        if (thr_debounce != 0) key_span(1'b1, $urandom_range(thr_debounce, 1));
                        key_span(1'b0, $urandom_range(thr_gap, 1));
                    end else begin
                        key_span(1'b1, $urandom_range(int'(thr_long) + 3, thr_long));
                        key_span(1'b0, $urandom_range(thr_gap, 1));
                    end
                end
            end
        end
    endtask

    task automatic test_saturation();
        begin
            set_thresholds(16'd0, 16'd1, 16'hFFFF, 16'hFFFF);
            key_span(1'b0, 2);
            key_span(1'b1, SAT_TICKS);  // saturated press is a long press
            key_span(1'b0, SAT_TICKS);  // saturated gap never ends the character
            key_span(1'b1, 1);
            key_span(1'b0, 1);
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = mkd_pkg::REG_DEBOUNCE;
        i_cfg_data      = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_alphabet();
        test_special_cases();
        test_backpressure();
        test_random_keying();
        test_saturation();

        wait_drain();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0 && key_events_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
